// ===== hdl/i2cmra_pkg.sv =====
// Shared types and constants for the I2C register access master.
// Depends on nothing; every other file in hdl/ imports it.
`timescale 1ns / 1ps

package i2cmra_pkg;

   // Register address width; the latched address is masked to this many bits.
   localparam int RegAddrBits = 16;
   localparam logic [15:0] RegAddrMask = 16'((32'd1 << RegAddrBits) - 32'd1);

   // Request function codes.
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // Configuration register indexes and reset values.
   localparam int CsrDataBits = 7;
   localparam logic CSR_DEV_ADDR   = 1'b0;
   localparam logic CSR_ADDR_BYTES = 1'b1;
   localparam logic [6:0] DevAddrReset   = 7'd64;
   localparam logic [1:0] AddrBytesReset = 2'd1;

   // Depth of the command and response queues.
   localparam int QDepth     = 4;
   localparam int QPtrBits   = $clog2(QDepth);
   localparam int QCountBits = $clog2(QDepth + 1);

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] reg_addr;
      logic [7:0]  wr_data;
      logic        sda_in;
   } req_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rd_data;
      logic       nack_seen;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_WRITE,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  reg_addr;
      logic [7:0]   wr_data;
      logic         sda_in;
   } cmd_type;

   typedef struct packed {
      logic                   wr_en;
      logic                   index;
      logic [CsrDataBits-1:0] wdata;
   } csr_type;

endpackage

// ===== hdl/i2cmra_front.sv =====
// Request front end: accepts requests and classifies the function code.
// Depends on i2cmra_pkg; feeds i2cmra_cmd_queue.
`timescale 1ns / 1ps

module i2cmra_front (
   input  logic               req_push,
   input  i2cmra_pkg::req_type req_data,
   output logic               req_full,
   input  logic               q_full,
   output logic               q_push,
   output i2cmra_pkg::cmd_type q_cmd
);
   import i2cmra_pkg::*;

   always_comb begin
      q_cmd.reg_addr = req_data.reg_addr;
      q_cmd.wr_data  = req_data.wr_data;
      q_cmd.sda_in   = req_data.sda_in;
      // The unused function code is a plain tick.
      unique case (req_data.func)
         FUNC_WRITE: q_cmd.kind = CMD_WRITE;
         FUNC_READ:  q_cmd.kind = CMD_READ;
         default:    q_cmd.kind = CMD_TICK;
      endcase
   end

   assign req_full = q_full;
   assign q_push   = req_push & ~q_full;

endmodule

// ===== hdl/i2cmra_cmd_queue.sv =====
// Short queue of classified commands between the front end and the sequencer.
// Depends on i2cmra_pkg.
`timescale 1ns / 1ps

module i2cmra_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  i2cmra_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output i2cmra_pkg::cmd_type pop_cmd,
   output logic               empty
);
   import i2cmra_pkg::*;

   cmd_type                mem_ff [QDepth];
   logic [QPtrBits-1:0]    wr_ptr_ff;
   logic [QPtrBits-1:0]    rd_ptr_ff;
   logic [QCountBits-1:0]  count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign full    = (count_ff == QCountBits'(QDepth));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPtrBits'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPtrBits'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCountBits'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QCountBits'(1);
         end
      end
   end

endmodule

// ===== hdl/i2cmra_rsp_queue.sv =====
// Output queue of bus-phase responses toward the consumer.
// Depends on i2cmra_pkg.
`timescale 1ns / 1ps

module i2cmra_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  i2cmra_pkg::rsp_type push_rsp,
   output logic               full,
   input  logic               pop,
   output i2cmra_pkg::rsp_type pop_rsp,
   output logic               empty
);
   import i2cmra_pkg::*;

   rsp_type                mem_ff [QDepth];
   logic [QPtrBits-1:0]    wr_ptr_ff;
   logic [QPtrBits-1:0]    rd_ptr_ff;
   logic [QCountBits-1:0]  count_ff;
   logic                   do_push;
   logic                   do_pop;

   assign full    = (count_ff == QCountBits'(QDepth));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_rsp = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rsp;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPtrBits'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPtrBits'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCountBits'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QCountBits'(1);
         end
      end
   end

endmodule

// ===== hdl/i2cmra_seq.sv =====
// Bus phase sequencer: runs one line phase per command and emits its levels.
// Depends on i2cmra_pkg; sits between i2cmra_cmd_queue and i2cmra_rsp_queue.
`timescale 1ns / 1ps

module i2cmra_seq (
   input  logic               clock,
   input  logic               reset,
   input  i2cmra_pkg::csr_type csr,
   input  logic               cmd_valid,
   input  i2cmra_pkg::cmd_type cmd,
   output logic               cmd_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output i2cmra_pkg::rsp_type rsp
);
   import i2cmra_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_S1, PH_S2, PH_S3, PH_S4,
      PH_WLO, PH_WHI, PH_ALO, PH_AHI,
      PH_RLO, PH_RHI, PH_NLO, PH_NHI,
      PH_P1, PH_P2, PH_P3
   } phase_type;

   // Which byte of the transaction is on the wire.
   localparam logic [2:0] BYTE_DEV_WR  = 3'd0;
   localparam logic [2:0] BYTE_ADDR_HI = 3'd1;
   localparam logic [2:0] BYTE_ADDR_LO = 3'd2;
   localparam logic [2:0] BYTE_DATA    = 3'd3;
   localparam logic [2:0] BYTE_DEV_RD  = 3'd4;

   phase_type   phase_ff, phase_in, cur_phase;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [2:0]  byte_idx_ff, byte_idx_in;
   logic [15:0] held_addr_ff, held_addr_in;
   logic [7:0]  held_data_ff, held_data_in;
   logic        is_read_ff, is_read_in;
   logic [7:0]  read_byte_ff, read_byte_in;
   logic [6:0]  dev_addr_ff;
   logic [1:0]  addr_bytes_ff;
   logic        step;
   logic        msb;
   rsp_type     rsp_in;

   function automatic logic [7:0] byte_for(input logic [2:0] idx, input logic [6:0] dev,
                                           input logic [15:0] addr, input logic [7:0] data);
      logic [7:0] b;
      unique case (idx)
         BYTE_DEV_WR:  b = {dev, 1'b0};
         BYTE_ADDR_HI: b = addr[15:8];
         BYTE_ADDR_LO: b = addr[7:0];
         BYTE_DATA:    b = data;
         default:      b = {dev, 1'b1};
      endcase
      return b;
   endfunction

   assign step     = cmd_valid & ~rsp_full;
   assign cmd_pop  = step;
   assign rsp_push = step;
   assign rsp      = rsp_in;
   assign msb      = shift_ff[7];

   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      byte_idx_in  = byte_idx_ff;
      held_addr_in = held_addr_ff;
      held_data_in = held_data_ff;
      is_read_in   = is_read_ff;
      read_byte_in = read_byte_ff;
      rsp_in.scl       = 1'b1;
      rsp_in.sda_out   = 1'b1;
      rsp_in.sda_drive = 1'b0;
      rsp_in.busy_res  = 1'b1;
      rsp_in.done_res  = 1'b0;
      rsp_in.nack_seen = 1'b0;
      cur_phase        = phase_ff;

      // A start request only counts on an idle bus; it shows the first start phase.
      if (phase_ff == PH_IDLE && cmd.kind != CMD_TICK) begin
         held_addr_in = cmd.reg_addr & RegAddrMask;
         held_data_in = cmd.wr_data;
         is_read_in   = (cmd.kind == CMD_READ);
         byte_idx_in  = BYTE_DEV_WR;
         bit_count_in = '0;
         cur_phase    = PH_S1;
      end

      unique case (cur_phase)
         PH_S1: begin
            rsp_in.scl = 1'b0; rsp_in.sda_out = 1'b1; rsp_in.sda_drive = 1'b1;
            phase_in = PH_S2;
         end
         PH_S2: begin
            rsp_in.scl = 1'b1; rsp_in.sda_out = 1'b1; rsp_in.sda_drive = 1'b1;
            phase_in = PH_S3;
         end
         PH_S3: begin
            rsp_in.scl = 1'b1; rsp_in.sda_out = 1'b0; rsp_in.sda_drive = 1'b1;
            phase_in = PH_S4;
         end
         PH_S4: begin
            rsp_in.scl = 1'b0; rsp_in.sda_out = 1'b0; rsp_in.sda_drive = 1'b1;
            shift_in     = byte_for(byte_idx_ff, dev_addr_ff, held_addr_ff, held_data_ff);
            bit_count_in = '0;
            phase_in     = PH_WLO;
         end
         PH_WLO: begin
            rsp_in.scl = 1'b0; rsp_in.sda_out = msb; rsp_in.sda_drive = 1'b1;
            phase_in = PH_WHI;
         end
         PH_WHI: begin
            rsp_in.scl = 1'b1; rsp_in.sda_out = msb; rsp_in.sda_drive = 1'b1;
            shift_in     = {shift_ff[6:0], 1'b0};
            bit_count_in = bit_count_ff + 4'd1;
            phase_in     = (bit_count_in >= 4'd8) ? PH_ALO : PH_WLO;
         end
         PH_ALO: begin
            rsp_in.scl = 1'b0;
            phase_in   = PH_AHI;
         end
         PH_AHI: begin
            rsp_in.scl = 1'b1;
            priority if (cmd.sda_in) begin
               // Not acknowledged: run the whole transaction again.
               rsp_in.nack_seen = 1'b1;
               byte_idx_in      = BYTE_DEV_WR;
               phase_in         = PH_S1;
            end else if (byte_idx_ff == BYTE_DEV_WR) begin
               byte_idx_in  = addr_bytes_ff[1] ? BYTE_ADDR_HI : BYTE_ADDR_LO;
               shift_in     = byte_for(byte_idx_in, dev_addr_ff, held_addr_ff, held_data_ff);
               bit_count_in = '0;
               phase_in     = PH_WLO;
            end else if (byte_idx_ff == BYTE_ADDR_HI) begin
               byte_idx_in  = BYTE_ADDR_LO;
               shift_in     = held_addr_ff[7:0];
               bit_count_in = '0;
               phase_in     = PH_WLO;
            end else if (byte_idx_ff == BYTE_ADDR_LO) begin
               if (is_read_ff) begin
                  // Repeated start, then the address byte with the read bit.
                  byte_idx_in = BYTE_DEV_RD;
                  phase_in    = PH_S1;
               end else begin
                  byte_idx_in  = BYTE_DATA;
                  shift_in     = held_data_ff;
                  bit_count_in = '0;
                  phase_in     = PH_WLO;
               end
            end else if (byte_idx_ff == BYTE_DEV_RD) begin
               shift_in     = '0;
               bit_count_in = '0;
               phase_in     = PH_RLO;
            end else begin
               phase_in = PH_P1;
            end
         end
         PH_RLO: begin
            rsp_in.scl = 1'b0;
            phase_in   = PH_RHI;
         end
         PH_RHI: begin
            rsp_in.scl   = 1'b1;
            shift_in     = {shift_ff[6:0], cmd.sda_in};
            bit_count_in = bit_count_ff + 4'd1;
            if (bit_count_in >= 4'd8) begin
               read_byte_in = shift_in;
               phase_in     = PH_NLO;
            end else begin
               phase_in = PH_RLO;
            end
         end
         PH_NLO: begin
            rsp_in.scl = 1'b0;
            phase_in   = PH_NHI;
         end
         PH_NHI: begin
            rsp_in.scl = 1'b1;
            phase_in   = PH_P1;
         end
         PH_P1: begin
            rsp_in.scl = 1'b0; rsp_in.sda_out = 1'b0; rsp_in.sda_drive = 1'b1;
            phase_in = PH_P2;
         end
         PH_P2: begin
            rsp_in.scl = 1'b1; rsp_in.sda_out = 1'b0; rsp_in.sda_drive = 1'b1;
            phase_in = PH_P3;
         end
         PH_P3: begin
            rsp_in.scl = 1'b1; rsp_in.sda_out = 1'b1; rsp_in.sda_drive = 1'b1;
            rsp_in.done_res = 1'b1;
            phase_in = PH_IDLE;
         end
         PH_IDLE: begin
            rsp_in.busy_res = 1'b0;
            phase_in        = PH_IDLE;
         end
      endcase

      // A released line reads as the pull-up level.
      if (!rsp_in.sda_drive) begin
         rsp_in.sda_out = 1'b1;
      end
      rsp_in.rd_data = read_byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         shift_ff      <= '0;
         byte_idx_ff   <= '0;
         held_addr_ff  <= '0;
         held_data_ff  <= '0;
         is_read_ff    <= 1'b0;
         read_byte_ff  <= '0;
         dev_addr_ff   <= DevAddrReset;
         addr_bytes_ff <= AddrBytesReset;
      end else begin
         if (step) begin
            phase_ff     <= phase_in;
            bit_count_ff <= bit_count_in;
            shift_ff     <= shift_in;
            byte_idx_ff  <= byte_idx_in;
            held_addr_ff <= held_addr_in;
            held_data_ff <= held_data_in;
            is_read_ff   <= is_read_in;
            read_byte_ff <= read_byte_in;
         end
         if (csr.wr_en) begin
            unique case (csr.index)
               CSR_DEV_ADDR:   dev_addr_ff   <= csr.wdata[6:0];
               CSR_ADDR_BYTES: addr_bytes_ff <= csr.wdata[1:0];
            endcase
         end
      end
   end

endmodule

// ===== hdl/i2c_master_register_access_top.sv =====
// Top level of the I2C register access master: front end, command queue,
// sequencer and response queue. Depends on i2cmra_pkg and the i2cmra_* modules.
`timescale 1ns / 1ps
//
//   Channel   Ports                               Direction   Moves
//   request   req_push, req_full, req_data        in          one line-phase tick
//   response  rsp_pop, rsp_empty, rsp_data        out         levels of that phase
//   csr       csr_wr_en, csr_index, csr_wdata     in          register write
//
// Every request yields exactly one response. A request is classified on the
// cycle it is accepted and queued; the sequencer runs one request per cycle
// while the response queue is not full, so the sustained rate is one request
// per clock when the consumer keeps up, set by the phase update of the
// sequencer state machine. A request accepted into empty queues is stepped by
// the sequencer in the next cycle and written into the response queue at the
// end of that cycle, from where the consumer can then pop it. Reset is
// synchronous and active high; it empties both queues, returns the bus to
// idle and restores the register defaults. When the consumer stalls, the
// response queue fills, the sequencer stops, and then the command queue
// fills and raises req_full; nothing is lost.

module i2c_master_register_access_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  i2cmra_pkg::req_type                  req_data,
   input  logic                                 rsp_pop,
   output logic                                 rsp_empty,
   output i2cmra_pkg::rsp_type                  rsp_data,
   input  logic                                 csr_wr_en,
   input  logic                                 csr_index,
   input  logic [i2cmra_pkg::CsrDataBits-1:0]   csr_wdata
);
   import i2cmra_pkg::*;

   logic    q_full;
   logic    q_push;
   cmd_type q_cmd;
   logic    cmd_empty;
   logic    cmd_pop;
   cmd_type cmd;
   logic    rsp_full;
   logic    rsp_push;
   rsp_type rsp;
   csr_type csr;

   // Register writes go to the sequencer unchecked; send them only when idle.
   assign csr.wr_en = csr_wr_en;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   i2cmra_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_cmd)
   );

   i2cmra_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (cmd_pop),
      .pop_cmd  (cmd),
      .empty    (cmd_empty)
   );

   i2cmra_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .cmd_valid (~cmd_empty),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (rsp)
   );

   i2cmra_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push),
      .push_rsp (rsp),
      .full     (rsp_full),
      .pop      (rsp_pop),
      .pop_rsp  (rsp_data),
      .empty    (rsp_empty)
   );

endmodule
